// ----- design/vgrc_pkg.sv -----
// shared types and constants of the voxel grid ray caster
// used by vgrc_ctrl, vgrc_dp and voxel_grid_ray_caster_top
`default_nettype none
package vgrc_pkg;
   localparam int GRID_AXIS_DEF = 32;
   localparam int ID_BITS_DEF   = 8;

   localparam logic [5:0] EXT_RESET = 6'd32;

   localparam logic [1:0] REG_EXT_X = 2'd0;
   localparam logic [1:0] REG_EXT_Y = 2'd1;
   localparam logic [1:0] REG_EXT_Z = 2'd2;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_LEFT  = 2'd1;
   localparam logic [1:0] OUT_DIST  = 2'd2;
   localparam logic [1:0] OUT_WRITE = 2'd3;

   localparam logic [2:0] FACE_NONE = 3'd0;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam int DIV_STEPS = 33;

   typedef struct packed {
      logic       load;
      logic       clr_step;
      logic       write;
      logic       div_step;
      logic       div_first;
      logic       mul_init;
      logic       leave;
      logic       eval;
      logic       end_mul;
      logic       end_sum;
      logic       end_fin;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic in_grid;
      logic eval_done;
   } status_type;
endpackage
`default_nettype wire

// ----- design/voxel_grid_ray_caster_top.sv -----
// voxel grid ray caster: voxel id store with 3d dda ray casting in q16.16
// how to use: pulse start with req_ fields while busy is low; a request is taken
// at that edge. operation 0 writes req_voxel_id at the floor cell of req_pos_*
// if inside the extents; operation 1 casts a ray from req_pos_* along req_dir_*.
// each request gives one result, shown on rsp_ ports for one cycle with
// rsp_valid high; the receiver cannot stall, so it must take it in that cycle.
// a write goes through the write state and the done state; the next request
// can be taken once busy is low again.
// a cast first sets up the three step lengths, each with the divider and then a
// multiply; then each cell inside the grid takes a read (one store read port,
// registered) and an evaluate step, and a cell outside it a read only; then the
// end point takes a multiply, a sum and a final step per axis, then the result.
// extents sit at csr byte addresses 0, 4, 8 (6 bits each, reset 32); write
// them only while busy is low.
// after reset the store is swept to empty, one entry a cycle, all GRID_AXIS^3
// entries (32768 at the default); busy stays high until the sweep ends.
// depends on vgrc_pkg, vgrc_ctrl, vgrc_dp
`default_nettype none
module voxel_grid_ray_caster_top #(
   parameter int GRID_AXIS = vgrc_pkg::GRID_AXIS_DEF,
   parameter int ID_BITS   = vgrc_pkg::ID_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire                req_operation,
   input  wire signed [31:0]  req_pos_x,
   input  wire signed [31:0]  req_pos_y,
   input  wire signed [31:0]  req_pos_z,
   input  wire signed [17:0]  req_dir_x,
   input  wire signed [17:0]  req_dir_y,
   input  wire signed [17:0]  req_dir_z,
   input  wire  [23:0]        req_max_distance,
   input  wire  [7:0]         req_voxel_id,
   output logic               rsp_valid,
   output logic [1:0]         rsp_outcome,
   output logic [7:0]         rsp_hit_id,
   output logic signed [31:0] rsp_cell_x,
   output logic signed [31:0] rsp_cell_y,
   output logic signed [31:0] rsp_cell_z,
   output logic [2:0]         rsp_face,
   output logic signed [31:0] rsp_end_x,
   output logic signed [31:0] rsp_end_y,
   output logic signed [31:0] rsp_end_z,
   output logic [30:0]        rsp_distance,
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire  [3:0]         csr_paddr,
   input  wire  [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import vgrc_pkg::*;

   logic [5:0] ext_x_ff, ext_y_ff, ext_z_ff;
   logic       csr_wr;
   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_x_ff <= EXT_RESET;
         ext_y_ff <= EXT_RESET;
         ext_z_ff <= EXT_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_EXT_X: ext_x_ff <= csr_pwdata[5:0];
            REG_EXT_Y: ext_y_ff <= csr_pwdata[5:0];
            REG_EXT_Z: ext_z_ff <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_EXT_X: csr_prdata = {26'd0, ext_x_ff};
         REG_EXT_Y: csr_prdata = {26'd0, ext_y_ff};
         REG_EXT_Z: csr_prdata = {26'd0, ext_z_ff};
         default:   csr_prdata = '0;
      endcase
   end

   vgrc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy),
      .done          (rsp_valid)
   );

   vgrc_dp #(
      .GRID_AXIS (GRID_AXIS),
      .ID_BITS   (ID_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .ext_x           (ext_x_ff),
      .ext_y           (ext_y_ff),
      .ext_z           (ext_z_ff),
      .in_pos_x        (req_pos_x),
      .in_pos_y        (req_pos_y),
      .in_pos_z        (req_pos_z),
      .in_dir_x        (req_dir_x),
      .in_dir_y        (req_dir_y),
      .in_dir_z        (req_dir_z),
      .in_max_distance (req_max_distance),
      .in_voxel_id     (req_voxel_id),
      .out_outcome     (rsp_outcome),
      .out_hit_id      (rsp_hit_id),
      .out_cell_x      (rsp_cell_x),
      .out_cell_y      (rsp_cell_y),
      .out_cell_z      (rsp_cell_z),
      .out_face        (rsp_face),
      .out_end_x       (rsp_end_x),
      .out_end_y       (rsp_end_y),
      .out_end_z       (rsp_end_z),
      .out_distance    (rsp_distance)
   );
endmodule
`default_nettype wire

// ----- design/vgrc_ctrl.sv -----
// controller state machine of the voxel grid ray caster
// depends on vgrc_pkg; drives vgrc_dp through cmd_type and reads status_type
`default_nettype none
module vgrc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  req_operation,
   input  vgrc_pkg::status_type status,
   output vgrc_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 done
);
   import vgrc_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_WRITE = 11'b00000000100,
      S_DIV   = 11'b00000001000,
      S_MUL   = 11'b00000010000,
      S_READ  = 11'b00000100000,
      S_EVAL  = 11'b00001000000,
      S_EMUL  = 11'b00010000000,
      S_ESUM  = 11'b00100000000,
      S_EFIN  = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               axis_in  = AXIS_X;
               cnt_in   = '0;
               state_in = req_operation ? S_DIV : S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_DONE;
         end
         S_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == 6'd0);
            cnt_in        = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_init = 1'b1;
            cnt_in       = '0;
            if (axis_ff == AXIS_Z) begin
               state_in = S_READ;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_DIV;
            end
         end
         S_READ: begin
            if (!status.in_grid) begin
               cmd.leave = 1'b1;
               axis_in   = AXIS_X;
               state_in  = S_EMUL;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (status.eval_done) begin
               axis_in  = AXIS_X;
               state_in = S_EMUL;
            end else begin
               state_in = S_READ;
            end
         end
         S_EMUL: begin
            cmd.end_mul = 1'b1;
            state_in    = S_ESUM;
         end
         S_ESUM: begin
            cmd.end_sum = 1'b1;
            state_in    = S_EFIN;
         end
         S_EFIN: begin
            cmd.end_fin = 1'b1;
            if (axis_ff == AXIS_Z) begin
               state_in = S_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_EMUL;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

   a_done_single: assert property (@(posedge clock) disable iff (reset) done |=> !done)
      else $error("result strobe longer than one cycle");
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> $past(state_ff == S_READ))
      else $error("step evaluated without a store read");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");
endmodule
`default_nettype wire

// ----- design/vgrc_dp.sv -----
// datapath of the voxel grid ray caster: voxel store, divider, dda step, end point
// depends on vgrc_pkg; sequenced by vgrc_ctrl
`default_nettype none
module vgrc_dp #(
   parameter int GRID_AXIS = vgrc_pkg::GRID_AXIS_DEF,
   parameter int ID_BITS   = vgrc_pkg::ID_BITS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  vgrc_pkg::cmd_type    cmd,
   output vgrc_pkg::status_type status,
   input  wire  [5:0]           ext_x,
   input  wire  [5:0]           ext_y,
   input  wire  [5:0]           ext_z,
   input  wire signed [31:0]    in_pos_x,
   input  wire signed [31:0]    in_pos_y,
   input  wire signed [31:0]    in_pos_z,
   input  wire signed [17:0]    in_dir_x,
   input  wire signed [17:0]    in_dir_y,
   input  wire signed [17:0]    in_dir_z,
   input  wire  [23:0]          in_max_distance,
   input  wire  [7:0]           in_voxel_id,
   output logic [1:0]           out_outcome,
   output logic [7:0]           out_hit_id,
   output logic signed [31:0]   out_cell_x,
   output logic signed [31:0]   out_cell_y,
   output logic signed [31:0]   out_cell_z,
   output logic [2:0]           out_face,
   output logic signed [31:0]   out_end_x,
   output logic signed [31:0]   out_end_y,
   output logic signed [31:0]   out_end_z,
   output logic [30:0]          out_distance
);
   import vgrc_pkg::*;

   localparam int DEPTH = GRID_AXIS * GRID_AXIS * GRID_AXIS;
   localparam int IW    = $clog2(DEPTH);
   localparam int TW    = 36;
   localparam logic [TW-1:0] T_INF = {1'b1, {(TW-1){1'b0}}};

   logic [ID_BITS-1:0] mem [DEPTH];
   logic [ID_BITS-1:0] rd_ff;
   logic [IW-1:0]      clr_ff;

   logic signed [31:0] pos_ff  [3];
   logic signed [17:0] dir_ff  [3];
   logic signed [31:0] cell_ff [3];
   logic signed [31:0] end_ff  [3];
   logic [TW-1:0]      delta_ff [3];
   logic [TW-1:0]      tmax_ff  [3];
   logic [23:0]        maxd_ff;
   logic [7:0]         id_ff;
   logic [34:0]        t_ff;
   logic [1:0]         outcome_ff;
   logic [7:0]         hit_ff;
   logic [2:0]         face_ff;
   logic               sat_ff;
   logic [17:0]        rem_ff;
   logic [32:0]        quo_ff;
   logic signed [36:0] plo_ff;
   logic signed [35:0] phi_ff;
   logic signed [53:0] prod_ff;

   logic [6:0]    lim_x, lim_y, lim_z;
   logic          in_grid;
   logic [IW-1:0] idx;
   logic signed [17:0] dir_a;
   logic [17:0]   mag;
   logic          dir_pos;
   logic [18:0]   shifted;
   logic          qbit;
   logic [17:0]   rem_n;
   logic [16:0]   dist0;
   logic [49:0]   tm_prod;
   logic          lt01, lt02, lt12;
   logic [1:0]    sel;
   logic [TW-1:0] tsel;
   logic          sel_inf;
   logic          over;
   logic          hit_nz;
   logic signed [37:0] end_sum;
   logic signed [31:0] end_sat;

   function automatic logic [6:0] clamp_ext(input logic [5:0] e);
      logic [6:0] g;
      g = 7'(GRID_AXIS);
      return ({1'b0, e} > g) ? g : {1'b0, e};
   endfunction

   function automatic logic in_range(input logic signed [31:0] c, input logic [6:0] l);
      return !c[31] && (c[30:0] < {24'd0, l});
   endfunction

   assign lim_x   = clamp_ext(ext_x);
   assign lim_y   = clamp_ext(ext_y);
   assign lim_z   = clamp_ext(ext_z);
   assign in_grid = in_range(cell_ff[0], lim_x) && in_range(cell_ff[1], lim_y)
                    && in_range(cell_ff[2], lim_z);
   assign idx = IW'(cell_ff[1][IW-1:0] * IW'(GRID_AXIS * GRID_AXIS))
              + IW'(cell_ff[2][IW-1:0] * IW'(GRID_AXIS))
              + cell_ff[0][IW-1:0];

   // shift-subtract divider for 2^32 / |dir|
   assign dir_a   = dir_ff[cmd.axis];
   assign mag     = dir_a[17] ? 18'(-dir_a) : 18'(dir_a);
   assign dir_pos = !dir_a[17] && (dir_a != 18'sd0);
   assign shifted = cmd.div_first ? 19'd1 : {rem_ff, 1'b0};
   assign qbit    = (shifted >= {1'b0, mag});
   assign rem_n   = qbit ? 18'(shifted - {1'b0, mag}) : shifted[17:0];

   assign dist0   = dir_pos ? 17'(17'h10000 - {1'b0, pos_ff[cmd.axis][15:0]})
                            : {1'b0, pos_ff[cmd.axis][15:0]};
   assign tm_prod = quo_ff * dist0;

   // axis choice, ties go to the later axis: z over y, y over x
   assign lt01    = tmax_ff[0] < tmax_ff[1];
   assign lt02    = tmax_ff[0] < tmax_ff[2];
   assign lt12    = tmax_ff[1] < tmax_ff[2];
   assign sel     = lt01 ? (lt02 ? 2'd0 : 2'd2) : (lt12 ? 2'd1 : 2'd2);
   assign tsel    = tmax_ff[sel];
   assign sel_inf = tsel[TW-1];
   assign over    = tsel[34:0] > {11'd0, maxd_ff};
   assign hit_nz  = (rd_ff != '0);

   assign end_sum = 38'(pos_ff[cmd.axis]) + 38'(prod_ff >>> 16);
   assign end_sat = (end_sum > 38'sd2147483647)  ? 32'sh7fffffff :
                    (end_sum < -38'sd2147483648) ? 32'sh80000000 : 32'(end_sum);

   assign status.clr_done  = (clr_ff == IW'(DEPTH - 1));
   assign status.in_grid   = in_grid;
   assign status.eval_done = hit_nz || sel_inf || over;

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_ff] <= '0;
      end else if (cmd.write && in_grid) begin
         mem[idx] <= ID_BITS'(id_ff);
      end
      rd_ff <= mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff[0]  <= in_pos_x;
         pos_ff[1]  <= in_pos_y;
         pos_ff[2]  <= in_pos_z;
         dir_ff[0]  <= in_dir_x;
         dir_ff[1]  <= in_dir_y;
         dir_ff[2]  <= in_dir_z;
         cell_ff[0] <= in_pos_x >>> 16;
         cell_ff[1] <= in_pos_y >>> 16;
         cell_ff[2] <= in_pos_z >>> 16;
         end_ff[0]  <= in_pos_x;
         end_ff[1]  <= in_pos_y;
         end_ff[2]  <= in_pos_z;
         maxd_ff    <= in_max_distance;
         id_ff      <= in_voxel_id;
         t_ff       <= '0;
         outcome_ff <= OUT_WRITE;
         hit_ff     <= '0;
         face_ff    <= FACE_NONE;
         sat_ff     <= 1'b0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_n;
         quo_ff <= cmd.div_first ? {32'd0, qbit} : {quo_ff[31:0], qbit};
      end
      if (cmd.mul_init) begin
         if (mag == 18'd0) begin
            delta_ff[cmd.axis] <= T_INF;
            tmax_ff[cmd.axis]  <= T_INF;
         end else begin
            delta_ff[cmd.axis] <= TW'(quo_ff);
            tmax_ff[cmd.axis]  <= TW'(tm_prod >> 16);
         end
      end
      if (cmd.leave) begin
         outcome_ff <= OUT_LEFT;
      end
      if (cmd.eval) begin
         if (hit_nz) begin
            outcome_ff <= OUT_HIT;
            hit_ff     <= 8'(rd_ff);
         end else if (sel_inf) begin
            outcome_ff <= OUT_DIST;
            sat_ff     <= 1'b1;
            face_ff    <= FACE_NONE;
         end else begin
            cell_ff[sel] <= dir_ff[sel][17] || (dir_ff[sel] == 18'sd0)
                            ? cell_ff[sel] - 32'sd1 : cell_ff[sel] + 32'sd1;
            t_ff         <= tsel[34:0];
            tmax_ff[sel] <= tsel + delta_ff[sel];
            if (over) begin
               outcome_ff <= OUT_DIST;
               face_ff    <= FACE_NONE;
            end else begin
               face_ff <= {sel, 1'b0}
                          + ((!dir_ff[sel][17] && (dir_ff[sel] != 18'sd0)) ? 3'd2 : 3'd1);
            end
         end
      end
      if (cmd.end_mul) begin
         plo_ff <= $signed({1'b0, t_ff[17:0]}) * dir_a;
         phi_ff <= $signed({1'b0, t_ff[34:18]}) * dir_a;
      end
      if (cmd.end_sum) begin
         prod_ff <= (54'(phi_ff) <<< 18) + 54'(plo_ff);
      end
      if (cmd.end_fin) begin
         end_ff[cmd.axis] <= end_sat;
      end
   end

   assign out_outcome  = outcome_ff;
   assign out_hit_id   = hit_ff;
   assign out_cell_x   = cell_ff[0];
   assign out_cell_y   = cell_ff[1];
   assign out_cell_z   = cell_ff[2];
   assign out_face     = face_ff;
   assign out_end_x    = end_ff[0];
   assign out_end_y    = end_ff[1];
   assign out_end_z    = end_ff[2];
   assign out_distance = (sat_ff || (t_ff[34:31] != 4'd0)) ? 31'h7fffffff : t_ff[30:0];
endmodule
`default_nettype wire

// ----- tb/tb_voxel_grid_ray_caster_top.sv -----
// testbench of voxel_grid_ray_caster_top: directed and random writes and ray casts
// checked field by field against a built-in voxel store and dda walk or fixed values
// depends on vgrc_pkg and voxel_grid_ray_caster_top
`timescale 1ns / 1ps
`default_nettype none
module tb_voxel_grid_ray_caster_top;
   import vgrc_pkg::*;

   localparam int AXIS = 32;
   localparam longint ONE = 65536;
   localparam logic [63:0] T_INF = 64'h4000_0000_0000_0000;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST = 1'b1;

   typedef struct {
      logic               op;
      logic signed [31:0] px, py, pz;
      logic signed [17:0] dx, dy, dz;
      logic [23:0]        maxd;
      logic [7:0]         id;
   } ray_req_type;

   typedef struct {
      logic [1:0]         outcome;
      logic [7:0]         hit;
      logic signed [31:0] cx, cy, cz;
      logic [2:0]         face;
      logic signed [31:0] ex, ey, ez;
      logic [30:0]        distance;
   } ray_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_operation = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [17:0] req_dir_x = 0, req_dir_y = 0, req_dir_z = 0;
   logic [23:0] req_max_distance = 0;
   logic [7:0] req_voxel_id = 0;
   logic rsp_valid;
   logic [1:0] rsp_outcome;
   logic [7:0] rsp_hit_id;
   logic signed [31:0] rsp_cell_x, rsp_cell_y, rsp_cell_z;
   logic [2:0] rsp_face;
   logic signed [31:0] rsp_end_x, rsp_end_y, rsp_end_z;
   logic [30:0] rsp_distance;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   voxel_grid_ray_caster_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .req_max_distance(req_max_distance), .req_voxel_id(req_voxel_id),
      .rsp_valid(rsp_valid), .rsp_outcome(rsp_outcome), .rsp_hit_id(rsp_hit_id),
      .rsp_cell_x(rsp_cell_x), .rsp_cell_y(rsp_cell_y), .rsp_cell_z(rsp_cell_z),
      .rsp_face(rsp_face),
      .rsp_end_x(rsp_end_x), .rsp_end_y(rsp_end_y), .rsp_end_z(rsp_end_z),
      .rsp_distance(rsp_distance),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   logic [7:0] voxels [AXIS*AXIS*AXIS];
   longint ext [3];
   ray_rsp_type expected_q [$];
   int err_count = 0;

   function automatic longint axis_lim(longint e);
      return (e > AXIS) ? AXIS : e;
   endfunction

   function automatic bit in_grid(longint c0, longint c1, longint c2);
      return c0 >= 0 && c0 < axis_lim(ext[0]) && c1 >= 0 && c1 < axis_lim(ext[1])
         && c2 >= 0 && c2 < axis_lim(ext[2]);
   endfunction

   function automatic int voxel_idx(longint c0, longint c1, longint c2);
      return int'((c1 * AXIS + c2) * AXIS + c0);
   endfunction

   // walks the grid and updates the voxel store for writes
   function automatic ray_rsp_type trace_ray(ray_req_type r);
      longint p [3], d [3], c [3], stp [3];
      logic [63:0] dl [3], tm [3];
      logic [63:0] t, fr, mg, dd;
      longint e;
      int a, stepped;
      bit inf_stop;
      ray_rsp_type o;
      p[0] = r.px; p[1] = r.py; p[2] = r.pz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      for (a = 0; a < 3; a++) c[a] = p[a] >>> 16;
      o.hit = 0;
      o.face = FACE_NONE;
      if (r.op == OP_WRITE) begin
         if (in_grid(c[0], c[1], c[2])) voxels[voxel_idx(c[0], c[1], c[2])] = r.id;
         o.outcome = OUT_WRITE;
         o.cx = c[0]; o.cy = c[1]; o.cz = c[2];
         o.ex = r.px; o.ey = r.py; o.ez = r.pz;
         o.distance = 0;
         return o;
      end
      for (a = 0; a < 3; a++) begin
         fr = p[a] - c[a] * ONE;
         mg = (d[a] < 0) ? -d[a] : d[a];
         stp[a] = (d[a] > 0) ? 1 : -1;
         dd = (stp[a] > 0) ? ONE - fr : fr;
         if (mg == 0) begin
            dl[a] = T_INF;
            tm[a] = T_INF;
         end else begin
            dl[a] = (64'd1 << 32) / mg;
            tm[a] = (dl[a] * dd) >> 16;
         end
      end
      t = 0;
      stepped = -1;
      inf_stop = 0;
      forever begin
         if (!in_grid(c[0], c[1], c[2])) begin
            o.outcome = OUT_LEFT;
            break;
         end
         o.hit = voxels[voxel_idx(c[0], c[1], c[2])];
         if (o.hit != 0) begin
            o.outcome = OUT_HIT;
            break;
         end
         if (tm[0] < tm[1]) a = (tm[0] < tm[2]) ? 0 : 2;
         else a = (tm[1] < tm[2]) ? 1 : 2;
         if (tm[a] >= T_INF) begin
            o.outcome = OUT_DIST;
            stepped = -1;
            inf_stop = 1;
            break;
         end
         c[a] += stp[a];
         t = tm[a];
         tm[a] += dl[a];
         stepped = a;
         if (t > {40'd0, r.maxd}) begin
            o.outcome = OUT_DIST;
            stepped = -1;
            break;
         end
      end
      if (stepped >= 0) o.face = 3'(stepped * 2 + ((stp[stepped] > 0) ? 2 : 1));
      if (inf_stop || t > 64'h7FFF_FFFF) o.distance = 31'h7FFF_FFFF;
      else o.distance = t[30:0];
      o.cx = c[0]; o.cy = c[1]; o.cz = c[2];
      for (a = 0; a < 3; a++) begin
         e = p[a] + ((longint'(t) * d[a]) >>> 16);
         if (e > 64'sd2147483647) e = 2147483647;
         if (e < -64'sd2147483648) e = -2147483648;
         if (a == 0) o.ex = e;
         else if (a == 1) o.ey = e;
         else o.ez = e;
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   always @(posedge clock) begin
      ray_rsp_type w;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_outcome, -1);
         end else begin
            w = expected_q.pop_front();
            if (rsp_outcome !== w.outcome) report_mismatch("outcome", rsp_outcome, w.outcome);
            if (rsp_hit_id !== w.hit) report_mismatch("hit_id", rsp_hit_id, w.hit);
            if (rsp_cell_x !== w.cx) report_mismatch("cell_x", rsp_cell_x, w.cx);
            if (rsp_cell_y !== w.cy) report_mismatch("cell_y", rsp_cell_y, w.cy);
            if (rsp_cell_z !== w.cz) report_mismatch("cell_z", rsp_cell_z, w.cz);
            if (rsp_face !== w.face) report_mismatch("face", rsp_face, w.face);
            if (rsp_end_x !== w.ex) report_mismatch("end_x", rsp_end_x, w.ex);
            if (rsp_end_y !== w.ey) report_mismatch("end_y", rsp_end_y, w.ey);
            if (rsp_end_z !== w.ez) report_mismatch("end_z", rsp_end_z, w.ez);
            if (rsp_distance !== w.distance)
               report_mismatch("distance", rsp_distance, w.distance);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(ray_req_type r, bit typed, ray_rsp_type want);
      ray_rsp_type got;
      int g;
      req_operation <= r.op;
      req_pos_x <= r.px; req_pos_y <= r.py; req_pos_z <= r.pz;
      req_dir_x <= r.dx; req_dir_y <= r.dy; req_dir_z <= r.dz;
      req_max_distance <= r.maxd;
      req_voxel_id <= r.id;
      start <= 1;
      do @(posedge clock); while (busy);
      got = trace_ray(r);
      expected_q.push_back(typed ? want : got);
      g = pick_gap();
      if (g > 0) begin
         start <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 0;
      @(posedge clock);
      while (expected_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] reg_idx, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      ext[reg_idx] = value[5:0];
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic set_extents(int x, int y, int z);
      settle();
      csr_write(REG_EXT_X, x);
      csr_write(REG_EXT_Y, y);
      csr_write(REG_EXT_Z, z);
   endtask

   function automatic ray_req_type mk(logic op, longint px, longint py, longint pz,
                                      longint dx, longint dy, longint dz,
                                      longint maxd, int id);
      ray_req_type r;
      r.op = op;
      r.px = px; r.py = py; r.pz = pz;
      r.dx = dx; r.dy = dy; r.dz = dz;
      r.maxd = maxd;
      r.id = id;
      return r;
   endfunction

   function automatic ray_rsp_type fixed_rsp(logic [1:0] oc, int hit, longint cx, longint cy,
                                             longint cz, longint ex, longint ey, longint ez,
                                             longint distance);
      ray_rsp_type o;
      o.outcome = oc;
      o.hit = hit;
      o.cx = cx; o.cy = cy; o.cz = cz;
      o.face = FACE_NONE;
      o.ex = ex; o.ey = ey; o.ez = ez;
      o.distance = distance;
      return o;
   endfunction

   function automatic longint rand_coord(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return longint'(signed'($urandom));
      if (r < 25) return longint'($urandom_range(0, span)) * ONE;
      return longint'($urandom_range(0, span)) * ONE + $urandom_range(0, 65535);
   endfunction

   function automatic longint rand_dir();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      if (r < 30) return longint'(signed'(18'($urandom)));
      if (r < 38) return ($urandom_range(0, 1) != 0) ? ONE : -ONE;
      return longint'($urandom_range(0, 131072)) - ONE;
   endfunction

   function automatic ray_req_type rand_request();
      ray_req_type r;
      int span;
      span = ($urandom_range(0, 1) != 0) ? 7 : 33;
      r = mk(($urandom_range(0, 99) < 35) ? OP_WRITE : OP_CAST,
             rand_coord(span), rand_coord(span), rand_coord(span),
             rand_dir(), rand_dir(), rand_dir(),
             ($urandom_range(0, 1) != 0) ? $urandom_range(0, 24'hFFFFFF)
                                          : $urandom_range(0, 20 * 65536),
             ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 255));
      return r;
   endfunction

   ray_req_type dir_req [$];
   ray_rsp_type dir_want [$];
   bit dir_typed [$];

   task automatic add_row(ray_req_type r, bit typed, ray_rsp_type want);
      dir_req.push_back(r);
      dir_typed.push_back(typed);
      dir_want.push_back(want);
   endtask

   initial begin
      ray_rsp_type none;
      int i, ph, n;
      int cfg [6][3];
      cfg = '{'{32, 32, 32}, '{1, 1, 1}, '{0, 32, 32},
              '{63, 5, 20}, '{0, 0, 0}, '{8, 8, 8}};
      none = fixed_rsp(OUT_HIT, 0, 0, 0, 0, 0, 0, 0, 0);
      foreach (voxels[k]) voxels[k] = 0;
      ext[0] = EXT_RESET; ext[1] = EXT_RESET; ext[2] = EXT_RESET;

      // directed rows: a cast through an empty grid after reset, then further writes and casts
      add_row(mk(OP_CAST, ONE/2, ONE/2, ONE/2, ONE, 0, 0, 24'hFFFFFF, 1), 0, none);
      add_row(mk(OP_WRITE, 3*ONE, 4*ONE, 5*ONE, 0, 0, 0, 0, 255), 1,
              fixed_rsp(OUT_WRITE, 0, 3, 4, 5, 3*ONE, 4*ONE, 5*ONE, 0));
      add_row(mk(OP_WRITE, -3*ONE/2, 4*ONE, 5*ONE, 0, 0, 0, 0, 7), 1,
              fixed_rsp(OUT_WRITE, 0, -2, 4, 5, -3*ONE/2, 4*ONE, 5*ONE, 0));
      add_row(mk(OP_WRITE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 9), 1,
              fixed_rsp(OUT_WRITE, 0, 32767, 32767, 32767,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
      add_row(mk(OP_WRITE, -2147483648, -2147483648, -2147483648, 0, 0, 0, 0, 9), 1,
              fixed_rsp(OUT_WRITE, 0, -32768, -32768, -32768,
                        -2147483648, -2147483648, -2147483648, 0));
      add_row(mk(OP_WRITE, 31*ONE+5, 31*ONE, 31*ONE, 0, 0, 0, 0, 1), 0, none);
      add_row(mk(OP_CAST, ONE/2, 4*ONE+ONE/2, 5*ONE+ONE/2, ONE, 0, 0, 24'hFFFFFF, 0), 0, none);
      add_row(mk(OP_CAST, ONE/2, ONE/2, ONE/2, 0, 0, 0, 24'hFFFFFF, 0), 1,
              fixed_rsp(OUT_DIST, 0, 0, 0, 0, ONE/2, ONE/2, ONE/2, 31'h7FFFFFFF));
      add_row(mk(OP_CAST, 3*ONE+ONE/2, 4*ONE+ONE/2, 5*ONE+ONE/2, 0, 0, 0, 0, 0), 1,
              fixed_rsp(OUT_HIT, 255, 3, 4, 5, 3*ONE+ONE/2, 4*ONE+ONE/2, 5*ONE+ONE/2, 0));
      add_row(mk(OP_CAST, -ONE/2, ONE, ONE, ONE, 0, 0, 24'hFFFFFF, 0), 1,
              fixed_rsp(OUT_LEFT, 0, -1, 1, 1, -ONE/2, ONE, ONE, 0));
      add_row(mk(OP_CAST, ONE/2, ONE/2, ONE/2, ONE, 0, 0, 0, 0), 0, none);
      add_row(mk(OP_CAST, ONE/2, ONE/2, ONE/2, ONE, ONE, ONE, 24'hFFFFFF, 0), 0, none);
      add_row(mk(OP_CAST, 2*ONE, 2*ONE, 2*ONE, -ONE, -ONE, -ONE, 24'hFFFFFF, 0), 0, none);
      add_row(mk(OP_CAST, 3*ONE, 4*ONE+ONE/2, 5*ONE+ONE/2, -ONE, 0, 0, 24'hFFFFFF, 0), 0, none);
      add_row(mk(OP_CAST, 30*ONE, 4*ONE+ONE/2, 5*ONE+ONE/2, -ONE, 1, -1, 24'hFFFFFF, 0),
              0, none);
      add_row(mk(OP_CAST, ONE/3, 31*ONE+ONE/2, ONE/7, 18'h1FFFF, -ONE, 18'h20000,
                 24'hFFFFFF, 0), 0, none);
      add_row(mk(OP_CAST, 31*ONE, 31*ONE, 31*ONE, ONE, ONE, ONE, 24'hFFFFFF, 0), 0, none);
      add_row(mk(OP_WRITE, 3*ONE, 4*ONE, 5*ONE, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(OP_CAST, ONE/2, 4*ONE+ONE/2, 5*ONE+ONE/2, ONE, 0, 0, 24'hFFFFFF, 0), 0, none);

      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      for (i = 0; i < dir_req.size(); i++) send_request(dir_req[i], dir_typed[i], dir_want[i]);

      for (ph = 0; ph < 7; ph++) begin
         if (ph < 6) set_extents(cfg[ph][0], cfg[ph][1], cfg[ph][2]);
         else set_extents($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32));
         n = (ph == 4) ? 30 : 85;
         for (i = 0; i < n; i++) send_request(rand_request(), 0, none);
      end

      settle();
      repeat (50) @(posedge clock);
      if (err_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
